### rtl/core/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants for the 16-to-8-bit min/max contrast stretch.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PixelW  = 8;
  // Quotient bits: the result never exceeds full scale, so 8 steps suffice
  localparam int unsigned QuotW   = 8;
  localparam int unsigned CntW    = $clog2(QuotW);
  // 255 * off, formed as (off << 8) - off
  localparam int unsigned ProdW   = SampleW + PixelW;

  localparam logic [SampleW-1:0] MinEmpty = '1;
  localparam logic [SampleW-1:0] MaxEmpty = '0;

  localparam logic [CntW-1:0] CntLast = CntW'(QuotW - 1);

  // Controller commands to the datapath
  typedef struct packed {
    logic gather;    // fold sample into min/max
    logic first;     // clear min/max before folding
    logic capture;   // latch a scale-mode sample
    logic setup;     // clamp, offset, range, scaled dividend
    logic step;      // one restoring-division step
  } mms_cmd_t;

endpackage : mms_pkg

### rtl/core/mms_ctrl.sv
// ----------------------------------------------------------------------------
// mms_ctrl
// Sequencer: takes requests, runs the divider steps and owns the result
// register's valid flag.
// ----------------------------------------------------------------------------
module mms_ctrl
  import mms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     mode_i,
  input  logic     first_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mms_cmd_t cmd_o,
  output logic     out_load_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            in_acc;
  logic            out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    out_load_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (mode_i) begin
            cmd_o.capture = 1'b1;
            state_d       = StSetup;
          end else begin
            cmd_o.gather = 1'b1;
            cmd_o.first  = first_i;
          end
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = StDiv;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          out_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load_o) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : mms_ctrl

### rtl/core/mms_dp.sv
// ----------------------------------------------------------------------------
// mms_dp
// Datapath: running min/max, clamp and offset, restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module mms_dp
  import mms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mms_cmd_t           cmd_i,
  input  logic               out_load_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [PixelW-1:0]  pixel_o
);

  logic [SampleW-1:0] min_q, max_q;
  logic [SampleW-1:0] min_base, max_base;
  logic [SampleW-1:0] samp_q;
  logic               bypass_q;
  logic [SampleW-1:0] range_q;
  logic [SampleW-1:0] rem_q, rem_d;
  logic [QuotW-1:0]   qsh_q, qsh_d;
  logic [PixelW-1:0]  pixel_q;
  logic [SampleW-1:0] clamped;
  logic [SampleW-1:0] off;
  logic [ProdW-1:0]   num;
  logic [SampleW:0]   trial;
  logic               ge;

  // Running min/max, with optional restart
  assign min_base = cmd_i.first ? MinEmpty : min_q;
  assign max_base = cmd_i.first ? MaxEmpty : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinEmpty;
      max_q <= MaxEmpty;
    end else if (cmd_i.gather) begin
      min_q <= (sample_i < min_base) ? sample_i : min_base;
      max_q <= (sample_i > max_base) ? sample_i : max_base;
    end
  end

  // Clamp into the gathered range and form 255 * offset
  always_comb begin
    clamped = samp_q;
    if (samp_q < min_q) begin
      clamped = min_q;
    end else if (samp_q > max_q) begin
      clamped = max_q;
    end
    off = clamped - min_q;
    num = {off, {PixelW{1'b0}}} - {{PixelW{1'b0}}, off};
  end

  // One restoring step: quotient shifts in, dividend bits shift out
  assign trial = {rem_q, qsh_q[QuotW-1]} - {1'b0, range_q};
  assign ge    = !trial[SampleW];

  always_comb begin
    rem_d = ge ? trial[SampleW-1:0] : {rem_q[SampleW-2:0], qsh_q[QuotW-1]};
    qsh_d = {qsh_q[QuotW-2:0], ge};
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q   <= sample_i;
      bypass_q <= (max_q <= min_q);
    end
    if (cmd_i.setup) begin
      range_q <= max_q - min_q;
      rem_q   <= num[ProdW-1:QuotW];
      qsh_q   <= num[QuotW-1:0];
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      qsh_q <= qsh_d;
    end
    if (out_load_i) begin
      pixel_q <= bypass_q ? samp_q[PixelW-1:0] : qsh_q;
    end
  end

  assign pixel_o = pixel_q;

endmodule : mms_dp

### rtl/core/minmax_stretch_to_8bit_top.sv
// ----------------------------------------------------------------------------
// minmax_stretch_to_8bit_top
// Linear min/max contrast stretch of 16-bit samples to 8-bit pixels.
// ----------------------------------------------------------------------------
// Each request carries mode, first and sample. Gather requests (mode 0) fold
// the sample into a running min/max, with first restarting both; they do
// not stall the input and give no result. Scale requests (mode 1) give one
// pixel, floor(255 * (clamped sample - min) / (max - min)), or the sample's
// low byte when nothing or a single level was gathered. After its capture a
// scale request holds off the input through clamp/offset setup, eight steps
// of a radix-2 restoring divider and the result load, which waits until the
// output register is free. The result sits in an output register, so the
// next request is taken while a finished pixel still waits downstream.
module minmax_stretch_to_8bit_top
  import mms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic               first_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixelW-1:0]  pixel_o
);

  mms_cmd_t cmd;
  logic     out_load;

  // Sequencer
  mms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .out_load_o  (out_load)
  );

  // Datapath
  mms_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .out_load_i (out_load),
    .sample_i   (sample_i),
    .pixel_o    (pixel_o)
  );

`ifndef ASSERT_OFF
  // A scale request keeps the input stalled while it is worked on
  a_scale_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i) |=> in_stall_o)
    else $error("scale request did not hold off the input");

  // A new result never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_o && out_stall_i))
    else $error("pending result overwritten");

  // Min/max update only on a request taken while idle
  a_gather_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.gather |-> (in_valid_i && !in_stall_o && !mode_i))
    else $error("gather command without a gather request");

  // Divider steps never overlap a result load, setup or capture
  a_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !out_load && !cmd.setup && !cmd.capture)
    else $error("divider step overlaps another command");
`endif

endmodule : minmax_stretch_to_8bit_top
